### rtl/assert_macros.svh
// assertion macros used by the serpent checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, skipped while reset is active
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, skipped while reset is active
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/serpent_pkg.sv
// serpent cipher package: payload types, state enums, s-box and linear transform functions
// no dependencies
package serpent_pkg;

    localparam int unsigned NumKeys = 33;
    localparam int unsigned NumRounds = 32;
    localparam int unsigned KeyWords = 132;
    localparam logic [31:0] Phi = 32'h9e3779b9;

    localparam logic [2:0] RegKeySize = 3'd0;
    localparam logic [2:0] RegKey01 = 3'd1;
    localparam logic [2:0] RegKey23 = 3'd2;
    localparam logic [2:0] RegKey45 = 3'd3;
    localparam logic [2:0] RegKey67 = 3'd4;

    localparam logic KindEnc = 1'b0;
    localparam logic KindDec = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [63:0] block_lo;
        logic [63:0] block_hi;
    } t_in;

    typedef struct packed {
        logic [63:0] result_lo;
        logic [63:0] result_hi;
    } t_out;

    typedef enum logic [2:0] {
        t_st_init,
        t_st_prekey,
        t_st_keygen,
        t_st_idle,
        t_st_load,
        t_st_round,
        t_st_done
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic       kgen_start;  // reset prekey window from key registers
        logic       kgen_word;   // produce one prekey word
        logic       kgen_store;  // write one round key
        logic [5:0] kidx;        // round key index
        logic       load;        // capture input block
        logic       rnd;         // run one round
        logic [5:0] rnd_idx;     // round number
        logic       fin;         // final key mixing
    } t_cmd;

    typedef logic [3:0] t_sbox [16];

    // one s-box per row, entry v in nibble v
    function automatic logic [3:0] sbox_fwd(input logic [2:0] b, input logic [3:0] v);
        logic [63:0] row;
        unique case (b)
            3'd0: row = 64'hc90724de_b56a1f83;
            3'd1: row = 64'h43d68eb1_a50972cf;
            3'd2: row = 64'h25b04e1d_fac39768;
            3'd3: row = 64'he57a421d_369c8bf0;
            3'd4: row = 64'hd7e9a452_6b0c38f1;
            3'd5: row = 64'h176d8e30_c9a4b25f;
            3'd6: row = 64'h0a3df19e_b6485c27;
            default: row = 64'h6539ac47_b28e0fd1;
        endcase
        return row[{v, 2'b00} +: 4];
    endfunction

    function automatic logic [3:0] sbox_inv(input logic [2:0] b, input logic [3:0] v);
        logic [3:0] o;
        o = 4'd0;
        for (int t = 0; t < 16; t++) begin
            if (sbox_fwd(b, 4'(t)) == v) begin
                o = 4'(t);
            end
        end
        return o;
    endfunction

    // bitsliced s-box over four words
    function automatic logic [127:0] sbox_slice(input logic [127:0] x, input logic [2:0] b,
                                                input logic inv);
        logic [127:0] y;
        logic [3:0] v;
        logic [3:0] o;
        y = '0;
        for (int j = 0; j < 32; j++) begin
            v = {x[96 + j], x[64 + j], x[32 + j], x[j]};
            o = inv ? sbox_inv(b, v) : sbox_fwd(b, v);
            y[j] = o[0];
            y[32 + j] = o[1];
            y[64 + j] = o[2];
            y[96 + j] = o[3];
        end
        return y;
    endfunction

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [127:0] lt_fwd(input logic [127:0] x);
        logic [31:0] a, b, c, d;
        a = x[31:0]; b = x[63:32]; c = x[95:64]; d = x[127:96];
        a = rol(a, 13); c = rol(c, 3);
        b = b ^ a ^ c; d = d ^ c ^ (a << 3);
        b = rol(b, 1); d = rol(d, 7);
        a = a ^ b ^ d; c = c ^ d ^ (b << 7);
        a = rol(a, 5); c = rol(c, 22);
        return {d, c, b, a};
    endfunction

    function automatic logic [127:0] lt_inv(input logic [127:0] x);
        logic [31:0] a, b, c, d;
        a = x[31:0]; b = x[63:32]; c = x[95:64]; d = x[127:96];
        c = rol(c, 10); a = rol(a, 27);
        c = c ^ d ^ (b << 7); a = a ^ b ^ d;
        d = rol(d, 25); b = rol(b, 31);
        d = d ^ c ^ (a << 3); b = b ^ a ^ c;
        c = rol(c, 29); a = rol(a, 19);
        return {d, c, b, a};
    endfunction

endpackage

### rtl/serpent_ctrl.sv
// serpent controller: key schedule sequencing and round sequencing
// depends on serpent_pkg
module serpent_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rekey,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  logic                i_kind,
    output serpent_pkg::t_cmd   o_cmd
);

    serpent_pkg::t_state r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic [1:0] r_sub, n_sub;
    logic       r_kind, n_kind;
    logic       r_pend, n_pend;

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_sub = r_sub;
        n_kind = r_kind;
        n_pend = r_pend | i_rekey;
        unique case (r_state)
            serpent_pkg::t_st_init: begin
                n_state = serpent_pkg::t_st_prekey;
                n_cnt = '0;
                n_sub = '0;
                n_pend = 1'b0;
            end
            serpent_pkg::t_st_prekey: begin
                n_state = serpent_pkg::t_st_keygen;
            end
            serpent_pkg::t_st_keygen: begin
                n_sub = r_sub + 2'd1;
                if (r_sub == 2'd3) begin
                    if (r_cnt == 6'(serpent_pkg::NumKeys - 1)) begin
                        n_state = serpent_pkg::t_st_idle;
                    end
                    n_cnt = r_cnt + 6'd1;
                end
            end
            serpent_pkg::t_st_idle: begin
                if (r_pend || i_rekey) begin
                    n_state = serpent_pkg::t_st_init;
                end else if (i_in_valid) begin
                    n_state = serpent_pkg::t_st_round;
                    n_kind = i_kind;
                    n_cnt = '0;
                end
            end
            serpent_pkg::t_st_load: begin
                n_state = serpent_pkg::t_st_round;
            end
            serpent_pkg::t_st_round: begin
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(serpent_pkg::NumRounds)) begin
                    n_state = serpent_pkg::t_st_done;
                end
            end
            serpent_pkg::t_st_done: begin
                if (i_out_ready) begin
                    n_state = serpent_pkg::t_st_idle;
                end
            end
            default: n_state = serpent_pkg::t_st_init;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        o_cmd.kidx = r_cnt;
        unique case (r_state)
            serpent_pkg::t_st_prekey: o_cmd.kgen_start = 1'b1;
            serpent_pkg::t_st_keygen: begin
                o_cmd.kgen_word = 1'b1;
                o_cmd.kgen_store = (r_sub == 2'd3);
            end
            serpent_pkg::t_st_idle: begin
                o_in_ready = !(r_pend || i_rekey);
                o_cmd.load = o_in_ready && i_in_valid;
            end
            serpent_pkg::t_st_round: begin
                o_cmd.fin = (r_cnt == 6'(serpent_pkg::NumRounds));
                o_cmd.rnd = !o_cmd.fin;
                o_cmd.rnd_idx = r_kind ? 6'(serpent_pkg::NumRounds - 1) - r_cnt : r_cnt;
            end
            serpent_pkg::t_st_done: o_out_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= serpent_pkg::t_st_init;
            r_cnt <= '0;
            r_sub <= '0;
            r_kind <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_sub <= n_sub;
            r_kind <= n_kind;
            r_pend <= n_pend;
        end
    end

endmodule

### rtl/serpent_dp.sv
// serpent datapath: key registers, prekey generator, round key memory, round unit
// depends on serpent_pkg
module serpent_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [63:0]       i_cfg_data,
    output logic              o_rekey,
    input  serpent_pkg::t_cmd i_cmd,
    input  serpent_pkg::t_in  i_in,
    output serpent_pkg::t_out o_out
);

    logic [1:0]   r_key_size;
    logic [63:0]  r_key [4];
    logic [31:0]  r_win [8];
    logic [7:0]   r_widx;
    logic [127:0] r_acc;
    logic [127:0] r_rk_mem [33];
    logic [127:0] r_rk;
    logic [127:0] r_x;
    logic         r_kind;
    logic [127:0] w_kword;
    logic [31:0]  w_new;
    logic [5:0]   w_rd_idx;
    logic [127:0] w_fwd, w_inv;
    logic [2:0]   w_box;

    // config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_size <= 2'd2;
            for (int i = 0; i < 4; i++) r_key[i] <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == serpent_pkg::RegKeySize) begin
                r_key_size <= i_cfg_data[1:0];
            end else if (i_cfg_idx <= serpent_pkg::RegKey67) begin
                r_key[2'(i_cfg_idx - 3'd1)] <= i_cfg_data;
            end
        end
    end

    assign o_rekey = i_cfg_we && (i_cfg_idx <= serpent_pkg::RegKey67);

    // prekey recurrence over an eight word window
    assign w_new = serpent_pkg::rol(r_win[0] ^ r_win[3] ^ r_win[5] ^ r_win[7]
                                    ^ serpent_pkg::Phi ^ {24'd0, r_widx}, 11);
    assign w_kword = {w_new, r_acc[127:32]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.kgen_start) begin
            r_widx <= '0;
            for (int i = 0; i < 8; i++) begin
                logic [63:0] kr;
                kr = r_key[i / 2];
                if (i < ((r_key_size == 2'd0) ? 4 : (r_key_size == 2'd1) ? 6 : 8)) begin
                    r_win[i] <= (i % 2 == 1) ? kr[63:32] : kr[31:0];
                end else if (i == ((r_key_size == 2'd0) ? 4 : (r_key_size == 2'd1) ? 6 : 8))
                begin
                    r_win[i] <= 32'd1;
                end else begin
                    r_win[i] <= '0;
                end
            end
        end else if (i_cmd.kgen_word) begin
            for (int i = 0; i < 7; i++) r_win[i] <= r_win[i + 1];
            r_win[7] <= w_new;
            r_widx <= r_widx + 8'd1;
            r_acc <= w_kword;
        end
    end

    // round key memory, one write port and one registered read port
    // encrypt fetches the next key up, decrypt the key just below the one in use
    assign w_rd_idx = i_cmd.load ? (i_in.kind ? 6'(serpent_pkg::NumRounds) : 6'd0)
                    : (i_cmd.rnd ? (r_kind ? i_cmd.rnd_idx
                                           : i_cmd.rnd_idx + 6'd1)
                                 : 6'd0);
    always_ff @(posedge i_clk) begin
        if (i_cmd.kgen_store) begin
            r_rk_mem[i_cmd.kidx] <= serpent_pkg::sbox_slice(w_kword,
                                        3'(6'd35 - i_cmd.kidx), 1'b0);
        end
        r_rk <= r_rk_mem[w_rd_idx];
    end

    // round unit
    assign w_box = i_cmd.rnd_idx[2:0];
    assign w_fwd = (i_cmd.rnd_idx == 6'(serpent_pkg::NumRounds - 1))
                 ? serpent_pkg::sbox_slice(r_x ^ r_rk, w_box, 1'b0)
                 : serpent_pkg::lt_fwd(serpent_pkg::sbox_slice(r_x ^ r_rk, w_box, 1'b0));
    // decrypt round: mix the pending key, undo the transform (not in the last round), inverse s-box
    assign w_inv = serpent_pkg::sbox_slice(
                       (i_cmd.rnd_idx == 6'(serpent_pkg::NumRounds - 1)) ? (r_x ^ r_rk)
                       : serpent_pkg::lt_inv(r_x ^ r_rk), w_box, 1'b1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_in.kind;
            r_x <= {i_in.block_hi, i_in.block_lo};
        end else if (i_cmd.rnd) begin
            if (r_kind == serpent_pkg::KindEnc) begin
                r_x <= w_fwd;
            end else begin
                r_x <= w_inv;
            end
        end else if (i_cmd.fin) begin
            r_x <= r_x ^ r_rk;
        end
    end

    assign o_out.result_lo = r_x[63:0];
    assign o_out.result_hi = r_x[127:64];

endmodule

### rtl/serpent_block_cipher_top.sv
// serpent cipher top: one 128-bit block per transaction, encrypt or decrypt
// each block runs 32 rounds plus final key mixing, one per cycle on the shared round unit;
// one block at a time; after reset and after each write to the key size or a key register,
// key expansion runs, during which no transaction is accepted; config writes are always taken
module serpent_block_cipher_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [63:0]           i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  serpent_pkg::t_in      i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output serpent_pkg::t_out     o_out_data
);

    serpent_pkg::t_cmd w_cmd;
    logic w_rekey;

    serpent_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_rekey(w_rekey),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_kind(i_in_data.kind), .o_cmd(w_cmd)
    );

    serpent_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data), .o_rekey(w_rekey),
        .i_cmd(w_cmd), .i_in(i_in_data), .o_out(o_out_data)
    );

endmodule

### rtl/serpent_chk.sv
// port-level checker for the serpent cipher top, bound to it
// depends on serpent_pkg and assert_macros.svh
`include "assert_macros.svh"
module serpent_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input serpent_pkg::t_out o_out_data
);
    // held result stays put until taken
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out_data))
    // one transaction at a time
    `ASSERT_IMPL(a_excl, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    // result valid is not withdrawn before it is taken
    `ASSERT_NEXT(a_out_valid_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    // no result the cycle after accept
    `ASSERT_NEXT(a_lat, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_out_valid)
endmodule

bind serpent_block_cipher_top serpent_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_ready(o_in_ready), .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
    .o_out_data(o_out_data)
);
